// ===== rtl/peak_hold_level_meter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Peak-hold level meter: assertion macros
// Shared property shapes, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PEAK_HOLD_LEVEL_METER_UNIT_DEFINES_SVH
`define PEAK_HOLD_LEVEL_METER_UNIT_DEFINES_SVH

// Same-cycle implication
`define PHLM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PHLM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/phlm_pkg.sv =====
// ----------------------------------------------------------------------------
// Peak-hold level meter package
// Field widths, register indexes, microcode encoding and the control store.
// ----------------------------------------------------------------------------
`default_nettype none

package phlm_pkg;

	// Field and register widths
	localparam int LEVEL_W = 16;
	localparam int ELAPSED_W = 16;
	localparam int POS_W = 12;
	localparam int HOLD_W = 12;
	localparam int STEP_REG_W = 10;
	localparam int PERIOD_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam int PROD_W = LEVEL_W + POS_W;
	localparam int BAR_SHIFT = 15;
	localparam int NUM_W = ELAPSED_W + STEP_REG_W;
	localparam int DROP_W = NUM_W + 1;
	localparam int CNT_W = 5;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POSITIONS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_PERIOD = 2'd3;

	// Register reset values
	localparam logic [POS_W-1:0] RST_POSITIONS = 12'd128;
	localparam logic [HOLD_W-1:0] RST_HOLD_TIME = 12'd400;
	localparam logic [STEP_REG_W-1:0] RST_FALL_STEP = 10'd1;
	localparam logic [PERIOD_W-1:0] RST_FALL_PERIOD = 10'd20;

	// Datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
	localparam logic [OP_W-1:0] OP_MULBAR = 4'd2;
	localparam logic [OP_W-1:0] OP_PEAK = 4'd3;
	localparam logic [OP_W-1:0] OP_HOLD = 4'd4;
	localparam logic [OP_W-1:0] OP_MULFALL = 4'd5;
	localparam logic [OP_W-1:0] OP_DIV = 4'd6;
	localparam logic [OP_W-1:0] OP_FALL = 4'd7;
	localparam logic [OP_W-1:0] OP_EMIT = 4'd8;

	// Jump conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_NONE = 3'd0;
	localparam logic [COND_W-1:0] C_NOREQ = 3'd1;
	localparam logic [COND_W-1:0] C_HOLD_LIVE = 3'd2;
	localparam logic [COND_W-1:0] C_CNT_NZ = 3'd3;
	localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd4;
	localparam logic [COND_W-1:0] C_ALWAYS = 3'd5;

	// Program steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] S_MULBAR = 4'd1;
	localparam logic [STEP_W-1:0] S_PEAK = 4'd2;
	localparam logic [STEP_W-1:0] S_HOLD = 4'd3;
	localparam logic [STEP_W-1:0] S_MULFALL = 4'd4;
	localparam logic [STEP_W-1:0] S_DIV = 4'd5;
	localparam logic [STEP_W-1:0] S_FALL = 4'd6;
	localparam logic [STEP_W-1:0] S_EMIT = 4'd7;
	localparam logic [STEP_W-1:0] S_RET = 4'd8;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic hold_live;
		logic cnt_nz;
		logic out_busy;
	} status_t;

	// Control store: jump to target when cond holds, else advance
	function automatic ctl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctl_t w;
		case (step)
			S_IDLE: w = '{op: OP_LOAD, cond: C_NOREQ, target: S_IDLE};
			S_MULBAR: w = '{op: OP_MULBAR, cond: C_NONE, target: S_IDLE};
			S_PEAK: w = '{op: OP_PEAK, cond: C_NONE, target: S_IDLE};
			S_HOLD: w = '{op: OP_HOLD, cond: C_HOLD_LIVE, target: S_EMIT};
			S_MULFALL: w = '{op: OP_MULFALL, cond: C_NONE, target: S_IDLE};
			S_DIV: w = '{op: OP_DIV, cond: C_CNT_NZ, target: S_DIV};
			S_FALL: w = '{op: OP_FALL, cond: C_NONE, target: S_IDLE};
			S_EMIT: w = '{op: OP_EMIT, cond: C_OUT_BUSY, target: S_EMIT};
			S_RET: w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
			default: w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/phlm_seq.sv =====
// ----------------------------------------------------------------------------
// Peak-hold level meter sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module phlm_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire phlm_pkg::status_t st,
	output phlm_pkg::ctl_t        ctl,
	output logic                  busy
);

	logic [phlm_pkg::STEP_W-1:0] step_q;
	logic take_jump;

	// Fetch the control word of the current step
	assign ctl = phlm_pkg::ucode_rom(step_q);
	assign busy = (step_q != phlm_pkg::S_IDLE);

	// Select the jump condition
	always_comb begin
		case (ctl.cond)
			phlm_pkg::C_NONE: take_jump = 1'b0;
			phlm_pkg::C_NOREQ: take_jump = !st.in_valid;
			phlm_pkg::C_HOLD_LIVE: take_jump = st.hold_live;
			phlm_pkg::C_CNT_NZ: take_jump = st.cnt_nz;
			phlm_pkg::C_OUT_BUSY: take_jump = st.out_busy;
			phlm_pkg::C_ALWAYS: take_jump = 1'b1;
			default: take_jump = 1'b1;
		endcase
	end

	// Advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= phlm_pkg::S_IDLE;
		end else if (take_jump) begin
			step_q <= ctl.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/peak_hold_level_meter_unit.sv =====
// ----------------------------------------------------------------------------
// Peak-hold level meter unit
// Scales a level to a bar index and tracks a held, then falling, peak.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries level (Q1.15) and elapsed_ms.
//   Output channel (out_valid/out_stall) returns bar_index and peak_position,
//   one result per request, in order.
//   Registers are written through cfg_we/cfg_index/cfg_data while idle.
// Sequence:
//   A request that keeps its peak on hold goes from its load step through the
//   bar multiply, peak and hold steps to emit, which fills the output register.
//   One whose hold has run out goes on through the fall multiply, a bit-serial
//   divider (one quotient bit per cycle over 26 bits) and the fall step before
//   emit.
//   in_stall is high from acceptance until the result has moved into the
//   output register and the program has returned to its idle step.
// Reset:
//   Peak and hold countdown clear to zero; registers take their defaults
//   (128 positions, 400 ms hold, step 1, period 20 ms); no result is valid.
// Stall:
//   A finished result waits in the output register; the program waits at
//   its emit step until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "peak_hold_level_meter_unit_defines.svh"

module peak_hold_level_meter_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [phlm_pkg::LEVEL_W-1:0]        level,
	input  wire logic [phlm_pkg::ELAPSED_W-1:0]      elapsed_ms,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [phlm_pkg::POS_W-1:0]               bar_index,
	output logic [phlm_pkg::POS_W-1:0]               peak_position,
	input  wire logic                                cfg_we,
	input  wire logic [phlm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [phlm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration registers
	logic [phlm_pkg::POS_W-1:0] positions_q;
	logic [phlm_pkg::HOLD_W-1:0] hold_time_q;
	logic [phlm_pkg::STEP_REG_W-1:0] fall_step_q;
	logic [phlm_pkg::PERIOD_W-1:0] fall_period_q;

	// Datapath registers
	logic [phlm_pkg::LEVEL_W-1:0] level_q;
	logic [phlm_pkg::ELAPSED_W-1:0] elapsed_q;
	logic [phlm_pkg::PROD_W-phlm_pkg::BAR_SHIFT-1:0] prod_q;
	logic [phlm_pkg::POS_W-1:0] bar_q;
	logic [phlm_pkg::POS_W-1:0] peak_q;
	logic [phlm_pkg::HOLD_W-1:0] hold_q;
	logic [phlm_pkg::NUM_W-1:0] num_q;
	logic [phlm_pkg::PERIOD_W-1:0] rem_q;
	logic [phlm_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic [phlm_pkg::POS_W-1:0] bar_out_q;
	logic [phlm_pkg::POS_W-1:0] peak_out_q;

	// Sequencer interface
	phlm_pkg::ctl_t ctl;
	phlm_pkg::status_t st;
	logic busy;

	// Combinational datapath
	logic [phlm_pkg::LEVEL_W-1:0] mul_a;
	logic [phlm_pkg::POS_W-1:0] mul_b;
	logic [phlm_pkg::PROD_W-1:0] product;
	logic [phlm_pkg::PROD_W-phlm_pkg::BAR_SHIFT-1:0] bar_raw;
	logic [phlm_pkg::POS_W-1:0] bar_clamped;
	logic hold_live;
	logic [phlm_pkg::PERIOD_W-1:0] period_eff;
	logic [phlm_pkg::PERIOD_W:0] rem_shift;
	logic rem_ge;
	logic [phlm_pkg::DROP_W-1:0] drop;
	logic out_busy;

	phlm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	assign in_stall = busy;
	assign out_busy = out_valid_q && out_stall;
	assign st = '{in_valid: in_valid, hold_live: hold_live,
		cnt_nz: (cnt_q != '0), out_busy: out_busy};

	// Share one multiplier between the bar scale and the fall numerator
	always_comb begin
		if (ctl.op == phlm_pkg::OP_MULBAR) begin
			mul_a = level_q;
			mul_b = positions_q;
		end else begin
			mul_a = elapsed_q;
			mul_b = {{(phlm_pkg::POS_W-phlm_pkg::STEP_REG_W){1'b0}}, fall_step_q};
		end
	end
	assign product = phlm_pkg::PROD_W'(mul_a) * phlm_pkg::PROD_W'(mul_b);

	// Clamp the scaled level to full scale
	assign bar_raw = prod_q;
	assign bar_clamped = (bar_raw > {1'b0, positions_q}) ? positions_q
		: bar_raw[phlm_pkg::POS_W-1:0];

	// Hold still running after this request's elapsed time
	assign hold_live = ({{(phlm_pkg::ELAPSED_W-phlm_pkg::HOLD_W){1'b0}}, hold_q} > elapsed_q);

	// Divider step: a zero period counts as one
	assign period_eff = (fall_period_q == '0) ? {{(phlm_pkg::PERIOD_W-1){1'b0}}, 1'b1}
		: fall_period_q;
	assign rem_shift = {rem_q, num_q[phlm_pkg::NUM_W-1]};
	assign rem_ge = (rem_shift >= {1'b0, period_eff});

	// Round the quotient up
	assign drop = {1'b0, num_q} + {{(phlm_pkg::DROP_W-1){1'b0}}, (rem_q != '0)};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			positions_q <= phlm_pkg::RST_POSITIONS;
			hold_time_q <= phlm_pkg::RST_HOLD_TIME;
			fall_step_q <= phlm_pkg::RST_FALL_STEP;
			fall_period_q <= phlm_pkg::RST_FALL_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				phlm_pkg::REG_POSITIONS: positions_q <= cfg_data[phlm_pkg::POS_W-1:0];
				phlm_pkg::REG_HOLD_TIME: hold_time_q <= cfg_data[phlm_pkg::HOLD_W-1:0];
				phlm_pkg::REG_FALL_STEP: fall_step_q <= cfg_data[phlm_pkg::STEP_REG_W-1:0];
				phlm_pkg::REG_FALL_PERIOD: fall_period_q <= cfg_data[phlm_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Peak state and countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			hold_q <= '0;
		end else begin
			case (ctl.op)
				phlm_pkg::OP_PEAK: begin
					if (bar_clamped > peak_q) begin
						peak_q <= bar_clamped;
						hold_q <= hold_time_q;
					end
				end
				phlm_pkg::OP_HOLD: begin
					if (hold_live) begin
						hold_q <= hold_q - elapsed_q[phlm_pkg::HOLD_W-1:0];
					end else begin
						hold_q <= '0;
					end
				end
				phlm_pkg::OP_FALL: begin
					if (drop >= {{(phlm_pkg::DROP_W-phlm_pkg::POS_W){1'b0}}, peak_q}) begin
						peak_q <= '0;
					end else begin
						peak_q <= peak_q - drop[phlm_pkg::POS_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the datapath
	always_ff @(posedge clk) begin
		case (ctl.op)
			phlm_pkg::OP_LOAD: begin
				level_q <= level;
				elapsed_q <= elapsed_ms;
			end
			phlm_pkg::OP_MULBAR: prod_q <= product[phlm_pkg::PROD_W-1:phlm_pkg::BAR_SHIFT];
			phlm_pkg::OP_PEAK: bar_q <= bar_clamped;
			phlm_pkg::OP_MULFALL: begin
				num_q <= product[phlm_pkg::NUM_W-1:0];
				rem_q <= '0;
			end
			phlm_pkg::OP_DIV: begin
				num_q <= {num_q[phlm_pkg::NUM_W-2:0], rem_ge};
				if (rem_ge) begin
					rem_q <= rem_shift[phlm_pkg::PERIOD_W-1:0]
						- period_eff;
				end else begin
					rem_q <= rem_shift[phlm_pkg::PERIOD_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Divider bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.op == phlm_pkg::OP_MULFALL) begin
			cnt_q <= phlm_pkg::CNT_W'(phlm_pkg::NUM_W - 1);
		end else if (ctl.op == phlm_pkg::OP_DIV && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == phlm_pkg::OP_EMIT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == phlm_pkg::OP_EMIT && !out_busy) begin
			bar_out_q <= bar_q;
			peak_out_q <= peak_q;
		end
	end

	assign out_valid = out_valid_q;
	assign bar_index = bar_out_q;
	assign peak_position = peak_out_q;

	// Checks
	`PHLM_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall,
		"request accepted but input not stalled next cycle")
	`PHLM_ASSERT_NOW(a_bar_in_scale, out_valid, bar_index <= positions_q,
		"bar index above full scale")
	`PHLM_ASSERT_NOW(a_rem_below_period, ctl.op == phlm_pkg::OP_FALL, rem_q < period_eff,
		"divider remainder not below period")

endmodule

`default_nettype wire

// ===== dv/peak_hold_level_meter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Peak-hold level meter unit testbench
// Drives level/elapsed requests and predicts the bar index and the held or
// falling peak for each one. Every returned result is checked in order
// against the prediction. Register settings change only while the unit is
// idle. Traffic runs under three idling mixes on the two channels.
// ----------------------------------------------------------------------------
module peak_hold_level_meter_unit_tb;

	localparam int STALL_LIMIT = 4000;
	localparam int BLOCKS_PER_MIX = 4;
	localparam int REQUESTS_PER_BLOCK = 170;

	typedef logic [phlm_pkg::LEVEL_W-1:0] level_t;
	typedef logic [phlm_pkg::ELAPSED_W-1:0] gap_t;
	typedef logic [phlm_pkg::CFG_DATA_W-1:0] cfg_word_t;
	typedef logic [phlm_pkg::PROD_W-1:0] prod_t;
	typedef logic [phlm_pkg::NUM_W-1:0] num_t;
	typedef logic [phlm_pkg::DROP_W-1:0] drop_t;
	typedef logic [phlm_pkg::PERIOD_W-1:0] period_t;

	typedef struct packed {
		logic [phlm_pkg::POS_W-1:0] bar;
		logic [phlm_pkg::POS_W-1:0] peak;
	} meter_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [phlm_pkg::LEVEL_W-1:0] level = '0;
	logic [phlm_pkg::ELAPSED_W-1:0] elapsed_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [phlm_pkg::POS_W-1:0] bar_index;
	logic [phlm_pkg::POS_W-1:0] peak_position;
	logic cfg_we = 1'b0;
	logic [phlm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [phlm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Register shadows and meter state of the predictor
	logic [phlm_pkg::POS_W-1:0] positions_q = phlm_pkg::RST_POSITIONS;
	logic [phlm_pkg::HOLD_W-1:0] hold_time_q = phlm_pkg::RST_HOLD_TIME;
	logic [phlm_pkg::STEP_REG_W-1:0] fall_step_q = phlm_pkg::RST_FALL_STEP;
	logic [phlm_pkg::PERIOD_W-1:0] fall_period_q = phlm_pkg::RST_FALL_PERIOD;
	logic [phlm_pkg::POS_W-1:0] held_peak = '0;
	logic [phlm_pkg::HOLD_W-1:0] hold_countdown = '0;

	meter_reading_t expected_readings[$];
	meter_reading_t head_reading;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int requests_sent = 0;
	int readings_checked = 0;
	int settings_loaded = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	peak_hold_level_meter_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.level(level),
		.elapsed_ms(elapsed_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bar_index(bar_index),
		.peak_position(peak_position),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Scale the level, update peak and countdown, return the expected reading
	function automatic meter_reading_t advance_meter(level_t lvl, gap_t gap);
		prod_t product;
		logic [phlm_pkg::PROD_W-phlm_pkg::BAR_SHIFT-1:0] scaled;
		logic [phlm_pkg::POS_W-1:0] bar;
		period_t period;
		num_t fall_num;
		drop_t drop;
		meter_reading_t r;
		product = prod_t'(lvl) * prod_t'(positions_q);
		scaled = product[phlm_pkg::PROD_W-1:phlm_pkg::BAR_SHIFT];
		bar = (scaled > {1'b0, positions_q}) ? positions_q
			: scaled[phlm_pkg::POS_W-1:0];
		if (bar > held_peak) begin
			held_peak = bar;
			hold_countdown = hold_time_q;
		end
		if (gap_t'(hold_countdown) > gap) begin
			hold_countdown = hold_countdown - gap[phlm_pkg::HOLD_W-1:0];
		end else begin
			period = (fall_period_q == '0) ? period_t'(1) : fall_period_q;
			fall_num = num_t'(fall_step_q) * num_t'(gap);
			drop = drop_t'(fall_num / num_t'(period))
				+ ((fall_num % num_t'(period) != '0) ? drop_t'(1) : drop_t'(0));
			hold_countdown = '0;
			held_peak = (drop >= drop_t'(held_peak)) ? '0
				: held_peak - drop[phlm_pkg::POS_W-1:0];
		end
		r.bar = bar;
		r.peak = held_peak;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("MISMATCH at %0t: %s, expected %0d, got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// Offer one request, hold it until accepted, queue its prediction
	task automatic send_request(level_t lvl, gap_t gap);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		level <= lvl;
		elapsed_ms <= gap;
		do @(posedge clk); while (in_stall);
		expected_readings.push_back(advance_meter(lvl, gap));
		requests_sent++;
	endtask

	// Drop valid and wait until every predicted reading has returned
	task automatic drain_readings();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges; the unit must be idle
	task automatic load_registers(cfg_word_t positions, cfg_word_t hold, cfg_word_t step,
			cfg_word_t period);
		cfg_we <= 1'b1;
		cfg_index <= phlm_pkg::REG_POSITIONS;
		cfg_data <= positions;
		@(posedge clk);
		cfg_index <= phlm_pkg::REG_HOLD_TIME;
		cfg_data <= hold;
		@(posedge clk);
		cfg_index <= phlm_pkg::REG_FALL_STEP;
		cfg_data <= step;
		@(posedge clk);
		cfg_index <= phlm_pkg::REG_FALL_PERIOD;
		cfg_data <= period;
		@(posedge clk);
		cfg_we <= 1'b0;
		positions_q = positions[phlm_pkg::POS_W-1:0];
		hold_time_q = hold[phlm_pkg::HOLD_W-1:0];
		fall_step_q = step[phlm_pkg::STEP_REG_W-1:0];
		fall_period_q = period[phlm_pkg::PERIOD_W-1:0];
		settings_loaded++;
	endtask

	// Reset defaults: zero, full scale, over-range level, hold, fall, floor at zero
	task automatic test_default_scaling_and_fall();
		send_request(16'h0000, 16'd0);
		send_request(16'h8000, 16'd0);
		send_request(16'hFFFF, 16'd100);
		send_request(16'h4000, 16'd299);
		send_request(16'h0000, 16'd1);
		send_request(16'h0000, 16'd37);
		send_request(16'h0000, 16'hFFFF);
		drain_readings();
	endtask

	// Register extremes: widest meter, zero hold, zero period, masked bits, zero positions
	task automatic test_register_extremes();
		load_registers(12'hFFF, 12'd0, 12'hFFF, 12'd0);
		send_request(16'hFFFF, 16'd0);
		send_request(16'h0000, 16'd1);
		send_request(16'h0001, 16'd0);
		send_request(16'h8000, 16'd2);
		send_request(16'h0000, 16'hFFFF);
		drain_readings();
		load_registers(12'd0, 12'd4095, 12'd1, 12'd1000);
		send_request(16'hFFFF, 16'd0);
		send_request(16'h8000, 16'd5);
		drain_readings();
		load_registers(12'd4095, 12'd4095, 12'd1000, 12'hFFF);
		send_request(16'h8000, 16'd0);
		send_request(16'h0000, 16'd4094);
		send_request(16'h0000, 16'd1);
		send_request(16'h0000, 16'd3);
		send_request(16'h7FFF, 16'd4096);
		drain_readings();
	endtask

	// Random settings and random traffic under one idling mix
	task automatic test_random_traffic(int sender_pct, int receiver_pct);
		cfg_word_t positions;
		cfg_word_t hold;
		cfg_word_t step;
		cfg_word_t period;
		level_t lvl;
		gap_t gap;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (int b = 0; b < BLOCKS_PER_MIX; b++) begin
			case ($urandom_range(3))
				0: positions = cfg_word_t'($urandom_range(1, 64));
				1: positions = cfg_word_t'($urandom_range(100, 300));
				2: positions = cfg_word_t'($urandom_range(0, 4095));
				default: positions = $urandom_range(1) ? 12'hFFF : 12'd0;
			endcase
			hold = $urandom_range(1) ? cfg_word_t'($urandom_range(0, 200))
				: cfg_word_t'($urandom_range(0, 4095));
			step = $urandom_range(1) ? cfg_word_t'($urandom_range(1, 8))
				: cfg_word_t'($urandom_range(0, 4095));
			period = $urandom_range(1) ? cfg_word_t'($urandom_range(1, 100))
				: cfg_word_t'($urandom_range(0, 4095));
			load_registers(positions, hold, step, period);
			for (int i = 0; i < REQUESTS_PER_BLOCK; i++) begin
				case ($urandom_range(3))
					0: lvl = level_t'($urandom);
					3: lvl = level_t'($urandom_range(16'h7000, 16'hFFFF));
					default: lvl = level_t'($urandom_range(0, 16'h8000));
				endcase
				case ($urandom_range(4))
					0: gap = gap_t'($urandom_range(0, 5));
					1: gap = gap_t'($urandom_range(0, 60));
					2: gap = gap_t'($urandom_range(0, 600));
					3: gap = gap_t'($urandom_range(0, 5000));
					default: gap = gap_t'($urandom);
				endcase
				// hold off new requests once until the unit has fully drained
				if (i == REQUESTS_PER_BLOCK / 2)
					drain_readings();
				send_request(lvl, gap);
			end
			drain_readings();
		end
	endtask

	// Compare each accepted result with the oldest prediction; randomize stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("result with no request pending", 0, 32'(bar_index));
			end else begin
				head_reading = expected_readings.pop_front();
				readings_checked++;
				if (bar_index !== head_reading.bar)
					report_mismatch("bar_index", 32'(head_reading.bar), 32'(bar_index));
				if (peak_position !== head_reading.peak)
					report_mismatch("peak_position", 32'(head_reading.peak),
						32'(peak_position));
			end
		end
		out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results pending",
				quiet_cycles, expected_readings.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_scaling_and_fall();
		test_register_extremes();
		test_random_traffic(21, 45);
		test_random_traffic(45, 21);
		test_random_traffic(0, 0);
		drain_readings();
		repeat (40) @(posedge clk);
		if (expected_readings.size() != 0)
			report_mismatch("results never returned", 0, expected_readings.size());
		$display("Sent %0d requests over %0d register settings and three idling mixes",
			requests_sent, settings_loaded);
		$display("Compared %0d results, %0d mismatches", readings_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
